// ----- rtl/omrq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// omrq_pkg
// Shared types and constants of the overwriting message ring queue: operation
// codes, field widths, default sizes and the item and result transfer structs.
// ----------------------------------------------------------------------------
package omrq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_MAX_BYTES   = 64;

    localparam int SRC_W  = 4;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_PEEK  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [SRC_W-1:0]  source;
        logic [BYTE_W-1:0] data_byte;
        logic              byte_valid;
        logic              end_of_message;
    } item_t;

    typedef struct packed {
        logic              found;
        logic [SRC_W-1:0]  msg_source;
        logic [BYTE_W-1:0] msg_byte;
        logic [LEN_W-1:0]  msg_length;
        logic              last_of_run;
    } result_t;

endpackage
`default_nettype wire

// ----- rtl/omrq_store.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// omrq_store
// Message storage: byte memory with one slot of MAX_BYTES per message, plus
// per-slot length and source tag. One write port each, registered reads.
// ----------------------------------------------------------------------------
module omrq_store #(
    parameter int QUEUE_DEPTH = omrq_pkg::DEF_QUEUE_DEPTH,
    parameter int MAX_BYTES   = omrq_pkg::DEF_MAX_BYTES
) (
    input  wire logic                                         clk,
    input  wire logic                                         byte_we,
    input  wire logic [$clog2(QUEUE_DEPTH*MAX_BYTES)-1:0]     byte_waddr,
    input  wire logic [omrq_pkg::BYTE_W-1:0]                  byte_wdata,
    input  wire logic                                         meta_we,
    input  wire logic [$clog2(QUEUE_DEPTH)-1:0]               meta_wslot,
    input  wire logic [$clog2(MAX_BYTES+1)-1:0]               meta_wlen,
    input  wire logic [omrq_pkg::SRC_W-1:0]                   meta_wsrc,
    input  wire logic                                         byte_re,
    input  wire logic [$clog2(QUEUE_DEPTH*MAX_BYTES)-1:0]     byte_raddr,
    output logic      [omrq_pkg::BYTE_W-1:0]                  byte_rdata,
    input  wire logic                                         meta_re,
    input  wire logic [$clog2(QUEUE_DEPTH)-1:0]               meta_rslot,
    output logic      [$clog2(MAX_BYTES+1)-1:0]               len_rdata,
    output logic      [omrq_pkg::SRC_W-1:0]                   src_rdata
);

    localparam int NBYTES = QUEUE_DEPTH * MAX_BYTES;
    localparam int LW     = $clog2(MAX_BYTES+1);

    logic [omrq_pkg::BYTE_W-1:0] byte_mem [NBYTES];
    logic [LW-1:0]               len_mem  [QUEUE_DEPTH];
    logic [omrq_pkg::SRC_W-1:0]  src_mem  [QUEUE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (byte_we)
        begin
            byte_mem[byte_waddr] <= byte_wdata;
        end
        if (byte_re)
        begin
            byte_rdata <= byte_mem[byte_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            len_mem[meta_wslot] <= meta_wlen;
            src_mem[meta_wslot] <= meta_wsrc;
        end
        if (meta_re)
        begin
            len_rdata <= len_mem[meta_rslot];
            src_rdata <= src_mem[meta_rslot];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/omrq_jobq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// omrq_jobq
// Two-entry queue of read jobs between the front and the back. Also reports
// whether a queued job still refers to a given slot.
// ----------------------------------------------------------------------------
module omrq_jobq #(
    parameter int QUEUE_DEPTH = omrq_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_push,
    input  wire logic                               in_found,
    input  wire logic [$clog2(QUEUE_DEPTH)-1:0]     in_slot,
    output logic                                    in_full,
    output logic                                    out_valid,
    output logic                                    out_found,
    output logic      [$clog2(QUEUE_DEPTH)-1:0]     out_slot,
    input  wire logic                               out_take,
    input  wire logic [$clog2(QUEUE_DEPTH)-1:0]     probe_slot,
    output logic                                    probe_hit
);

    localparam int SW = $clog2(QUEUE_DEPTH);

    logic          found_mem [2];
    logic [SW-1:0] slot_mem  [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    cnt_reg;
    logic          vld0;
    logic          vld1;
    logic          do_push;
    logic          do_take;

    assign in_full   = (cnt_reg == 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_found = found_mem[rd_ptr_reg];
    assign out_slot  = slot_mem[rd_ptr_reg];
    assign do_push   = in_push && !in_full;
    assign do_take   = out_take && out_valid;

    // entry validity from fill count and read pointer
    always_comb
    begin
        vld0 = (cnt_reg == 2'd2) || ((cnt_reg == 2'd1) && (rd_ptr_reg == 1'b0));
        vld1 = (cnt_reg == 2'd2) || ((cnt_reg == 2'd1) && (rd_ptr_reg == 1'b1));
        probe_hit = (vld0 && found_mem[0] && (slot_mem[0] == probe_slot)) ||
                    (vld1 && found_mem[1] && (slot_mem[1] == probe_slot));
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            found_mem[wr_ptr_reg] <= in_found;
            slot_mem[wr_ptr_reg]  <= in_slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_take)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_take)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (do_take && !do_push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/omrq_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// omrq_front
// Command front end: takes items, writes pushed bytes and message metadata,
// keeps head, tail and fill count, and turns pop and peek into read jobs.
// ----------------------------------------------------------------------------
module omrq_front #(
    parameter int QUEUE_DEPTH = omrq_pkg::DEF_QUEUE_DEPTH,
    parameter int MAX_BYTES   = omrq_pkg::DEF_MAX_BYTES
) (
    input  wire logic                                         clk,
    input  wire logic                                         rst_n,
    input  wire logic                                         push,
    input  wire omrq_pkg::item_t                              item,
    output logic                                              full,
    input  wire logic                                         jobq_full,
    input  wire logic                                         jobq_hit,
    input  wire logic                                         back_active,
    input  wire logic [$clog2(QUEUE_DEPTH)-1:0]               back_slot,
    output logic      [$clog2(QUEUE_DEPTH)-1:0]               head_slot,
    output logic                                              byte_we,
    output logic      [$clog2(QUEUE_DEPTH*MAX_BYTES)-1:0]     byte_waddr,
    output logic      [omrq_pkg::BYTE_W-1:0]                  byte_wdata,
    output logic                                              meta_we,
    output logic      [$clog2(MAX_BYTES+1)-1:0]               meta_wlen,
    output logic      [omrq_pkg::SRC_W-1:0]                   meta_wsrc,
    output logic                                              job_push,
    output logic                                              job_found,
    output logic      [$clog2(QUEUE_DEPTH)-1:0]               job_slot
);

    localparam int SW = $clog2(QUEUE_DEPTH);
    localparam int LW = $clog2(MAX_BYTES+1);
    localparam int AW = $clog2(QUEUE_DEPTH*MAX_BYTES);

    logic [SW-1:0] head_reg;
    logic [SW-1:0] head_next;
    logic [SW-1:0] tail_reg;
    logic [SW-1:0] tail_next;
    logic [LW-1:0] count_reg;
    logic [LW-1:0] count_next;
    logic [SW-1:0] head_adv;
    logic [SW-1:0] newest;
    logic          accept;

    function automatic logic [SW-1:0] adv(input logic [SW-1:0] s);
        logic [SW-1:0] r;
        if (s == SW'(QUEUE_DEPTH-1))
        begin
            r = '0;
        end
        else
        begin
            r = s + SW'(1);
        end
        return r;
    endfunction

    assign head_slot  = head_reg;
    assign byte_waddr = AW'(head_reg) * AW'(MAX_BYTES) + AW'(count_reg);
    assign byte_wdata = item.data_byte;
    assign meta_wsrc  = item.source;

    always_comb
    begin
        // the slot being filled may still be read by a queued or running job
        full      = jobq_full || jobq_hit || (back_active && (back_slot == head_reg));
        accept    = push && !full;
        head_adv  = adv(head_reg);
        newest    = (head_reg == '0) ? SW'(QUEUE_DEPTH-1) : head_reg - SW'(1);
        head_next = head_reg;
        tail_next = tail_reg;
        count_next = count_reg;
        byte_we   = 1'b0;
        meta_we   = 1'b0;
        meta_wlen = count_reg;
        job_push  = 1'b0;
        job_found = 1'b0;
        job_slot  = tail_reg;
        if (accept)
        begin
            case (item.op)
                omrq_pkg::OP_PUSH:
                begin
                    byte_we   = item.byte_valid && (count_reg < LW'(MAX_BYTES));
                    meta_wlen = count_reg + LW'(byte_we);
                    if (item.end_of_message)
                    begin
                        meta_we    = 1'b1;
                        head_next  = head_adv;
                        count_next = '0;
                        if (head_adv == tail_reg)
                        begin
                            tail_next = adv(tail_reg);
                        end
                    end
                    else
                    begin
                        count_next = meta_wlen;
                    end
                end
                omrq_pkg::OP_POP:
                begin
                    job_push = 1'b1;
                    if (tail_reg != head_reg)
                    begin
                        job_found = 1'b1;
                        job_slot  = tail_reg;
                        tail_next = adv(tail_reg);
                    end
                end
                omrq_pkg::OP_PEEK:
                begin
                    job_push = 1'b1;
                    if (tail_reg != head_reg)
                    begin
                        job_found = 1'b1;
                        job_slot  = newest;
                    end
                end
                omrq_pkg::OP_CLEAR:
                begin
                    tail_next = head_reg;
                end
                default:
                begin
                    tail_next = tail_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/omrq_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// omrq_back
// Read back end: takes one job at a time, loads the slot metadata, streams
// the bytes into the consumer's result queue, one per cycle while it has room.
// ----------------------------------------------------------------------------
module omrq_back #(
    parameter int QUEUE_DEPTH = omrq_pkg::DEF_QUEUE_DEPTH,
    parameter int MAX_BYTES   = omrq_pkg::DEF_MAX_BYTES
) (
    input  wire logic                                         clk,
    input  wire logic                                         rst_n,
    input  wire logic                                         job_valid,
    input  wire logic                                         job_found,
    input  wire logic [$clog2(QUEUE_DEPTH)-1:0]               job_slot,
    output logic                                              job_take,
    output logic                                              meta_re,
    output logic      [$clog2(QUEUE_DEPTH)-1:0]               meta_rslot,
    input  wire logic [$clog2(MAX_BYTES+1)-1:0]               len_rdata,
    input  wire logic [omrq_pkg::SRC_W-1:0]                   src_rdata,
    output logic                                              byte_re,
    output logic      [$clog2(QUEUE_DEPTH*MAX_BYTES)-1:0]     byte_raddr,
    input  wire logic [omrq_pkg::BYTE_W-1:0]                  byte_rdata,
    output logic                                              active,
    output logic      [$clog2(QUEUE_DEPTH)-1:0]               active_slot,
    output logic                                              empty,
    input  wire logic                                         pop,
    output omrq_pkg::result_t                                 result
);

    localparam int SW = $clog2(QUEUE_DEPTH);
    localparam int LW = $clog2(MAX_BYTES+1);
    localparam int AW = $clog2(QUEUE_DEPTH*MAX_BYTES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic [SW-1:0]              slot_reg;
    logic [SW-1:0]              slot_next;
    logic [LW-1:0]              len_reg;
    logic [LW-1:0]              len_next;
    logic [omrq_pkg::SRC_W-1:0] src_reg;
    logic [omrq_pkg::SRC_W-1:0] src_next;
    logic [LW-1:0]              k_reg;
    logic [LW-1:0]              k_next;
    logic                       d_valid_reg;
    logic                       d_valid_next;
    logic                       d_found_reg;
    logic                       d_found_next;
    logic [omrq_pkg::SRC_W-1:0] d_src_reg;
    logic [omrq_pkg::SRC_W-1:0] d_src_next;
    logic [LW-1:0]              d_len_reg;
    logic [LW-1:0]              d_len_next;
    logic                       d_last_reg;
    logic                       d_last_next;
    logic                       d_zero_reg;
    logic                       d_zero_next;
    logic                       d_push;
    logic                       advance;
    logic                       run_last;

    omrq_pkg::result_t          rq_mem [2];
    omrq_pkg::result_t          rq_in;
    logic                       rq_wr_reg;
    logic                       rq_rd_reg;
    logic [1:0]                 rq_cnt_reg;
    logic                       rq_pop;

    assign active      = (state_reg != ST_IDLE);
    assign active_slot = slot_reg;
    assign meta_rslot  = job_slot;
    assign byte_raddr  = AW'(slot_reg) * AW'(MAX_BYTES) + AW'(k_reg);
    assign d_push      = d_valid_reg && (rq_cnt_reg != 2'd2);
    assign advance     = !d_valid_reg || d_push;
    assign run_last    = (len_reg == '0) || ((k_reg + LW'(1)) == len_reg);

    always_comb
    begin
        state_next   = state_reg;
        slot_next    = slot_reg;
        len_next     = len_reg;
        src_next     = src_reg;
        k_next       = k_reg;
        d_valid_next = d_valid_reg && !d_push;
        d_found_next = d_found_reg;
        d_src_next   = d_src_reg;
        d_len_next   = d_len_reg;
        d_last_next  = d_last_reg;
        d_zero_next  = d_zero_reg;
        job_take     = 1'b0;
        meta_re      = 1'b0;
        byte_re      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid && job_found)
                begin
                    job_take   = 1'b1;
                    meta_re    = 1'b1;
                    slot_next  = job_slot;
                    state_next = ST_LOAD;
                end
                else if (job_valid && advance)
                begin
                    // not-found result
                    job_take     = 1'b1;
                    d_valid_next = 1'b1;
                    d_found_next = 1'b0;
                    d_src_next   = '0;
                    d_len_next   = '0;
                    d_last_next  = 1'b1;
                    d_zero_next  = 1'b1;
                end
            end
            ST_LOAD:
            begin
                len_next   = len_rdata;
                src_next   = src_rdata;
                k_next     = '0;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (advance)
                begin
                    byte_re      = (len_reg != '0);
                    d_valid_next = 1'b1;
                    d_found_next = 1'b1;
                    d_src_next   = src_reg;
                    d_len_next   = len_reg;
                    d_last_next  = run_last;
                    d_zero_next  = (len_reg == '0);
                    k_next       = k_reg + LW'(1);
                    if (run_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            d_valid_reg <= d_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg    <= slot_next;
        len_reg     <= len_next;
        src_reg     <= src_next;
        k_reg       <= k_next;
        d_found_reg <= d_found_next;
        d_src_reg   <= d_src_next;
        d_len_reg   <= d_len_next;
        d_last_reg  <= d_last_next;
        d_zero_reg  <= d_zero_next;
    end

    // result queue
    always_comb
    begin
        rq_in.found       = d_found_reg;
        rq_in.msg_source  = d_src_reg;
        rq_in.msg_byte    = d_zero_reg ? '0 : byte_rdata;
        rq_in.msg_length  = omrq_pkg::LEN_W'(d_len_reg);
        rq_in.last_of_run = d_last_reg;
    end

    assign empty  = (rq_cnt_reg == 2'd0);
    assign result = rq_mem[rq_rd_reg];
    assign rq_pop = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (d_push)
        begin
            rq_mem[rq_wr_reg] <= rq_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rq_wr_reg  <= 1'b0;
            rq_rd_reg  <= 1'b0;
            rq_cnt_reg <= 2'd0;
        end
        else
        begin
            if (d_push)
            begin
                rq_wr_reg <= ~rq_wr_reg;
            end
            if (rq_pop)
            begin
                rq_rd_reg <= ~rq_rd_reg;
            end
            if (d_push && !rq_pop)
            begin
                rq_cnt_reg <= rq_cnt_reg + 2'd1;
            end
            else if (rq_pop && !d_push)
            begin
                rq_cnt_reg <= rq_cnt_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/overwriting_message_ring_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// overwriting_message_ring_queue
// Ring queue of tagged variable-length messages that drops the oldest message
// when full. Pop streams the oldest message out, peek streams the newest.
//
//   channel   handshake          payload
//   item      push / full        omrq_pkg::item_t
//   result    empty / pop        omrq_pkg::result_t
//
// push and clear items are accepted one per cycle while full is low.
// pop and peek produce max(1, length) results, one per cycle while the result
// queue has room, after a metadata lookup when the message exists; up to two
// read jobs wait between front and back. full rises while the job queue holds
// two jobs or while a queued or running job still uses the slot being filled.
// reset clears pointers and control only; message storage is not cleared.
// ----------------------------------------------------------------------------
module overwriting_message_ring_queue #(
    parameter int QUEUE_DEPTH = omrq_pkg::DEF_QUEUE_DEPTH,
    parameter int MAX_BYTES   = omrq_pkg::DEF_MAX_BYTES
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire omrq_pkg::item_t   item,
    output logic                   empty,
    input  wire logic              pop,
    output omrq_pkg::result_t      result
);

    localparam int SW = $clog2(QUEUE_DEPTH);
    localparam int LW = $clog2(MAX_BYTES+1);
    localparam int AW = $clog2(QUEUE_DEPTH*MAX_BYTES);

    logic                        jobq_full;
    logic                        jobq_hit;
    logic                        back_active;
    logic [SW-1:0]               back_slot;
    logic [SW-1:0]               head_slot;
    logic                        byte_we;
    logic [AW-1:0]               byte_waddr;
    logic [omrq_pkg::BYTE_W-1:0] byte_wdata;
    logic                        meta_we;
    logic [LW-1:0]               meta_wlen;
    logic [omrq_pkg::SRC_W-1:0]  meta_wsrc;
    logic                        job_push;
    logic                        job_found;
    logic [SW-1:0]               job_slot;
    logic                        jq_valid;
    logic                        jq_found;
    logic [SW-1:0]               jq_slot;
    logic                        jq_take;
    logic                        meta_re;
    logic [SW-1:0]               meta_rslot;
    logic [LW-1:0]               len_rdata;
    logic [omrq_pkg::SRC_W-1:0]  src_rdata;
    logic                        byte_re;
    logic [AW-1:0]               byte_raddr;
    logic [omrq_pkg::BYTE_W-1:0] byte_rdata;

    omrq_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_BYTES   (MAX_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .item        (item),
        .full        (full),
        .jobq_full   (jobq_full),
        .jobq_hit    (jobq_hit),
        .back_active (back_active),
        .back_slot   (back_slot),
        .head_slot   (head_slot),
        .byte_we     (byte_we),
        .byte_waddr  (byte_waddr),
        .byte_wdata  (byte_wdata),
        .meta_we     (meta_we),
        .meta_wlen   (meta_wlen),
        .meta_wsrc   (meta_wsrc),
        .job_push    (job_push),
        .job_found   (job_found),
        .job_slot    (job_slot)
    );

    omrq_jobq #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_jobq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_push     (job_push),
        .in_found    (job_found),
        .in_slot     (job_slot),
        .in_full     (jobq_full),
        .out_valid   (jq_valid),
        .out_found   (jq_found),
        .out_slot    (jq_slot),
        .out_take    (jq_take),
        .probe_slot  (head_slot),
        .probe_hit   (jobq_hit)
    );

    omrq_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_BYTES   (MAX_BYTES)
    ) u_store (
        .clk         (clk),
        .byte_we     (byte_we),
        .byte_waddr  (byte_waddr),
        .byte_wdata  (byte_wdata),
        .meta_we     (meta_we),
        .meta_wslot  (head_slot),
        .meta_wlen   (meta_wlen),
        .meta_wsrc   (meta_wsrc),
        .byte_re     (byte_re),
        .byte_raddr  (byte_raddr),
        .byte_rdata  (byte_rdata),
        .meta_re     (meta_re),
        .meta_rslot  (meta_rslot),
        .len_rdata   (len_rdata),
        .src_rdata   (src_rdata)
    );

    omrq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_BYTES   (MAX_BYTES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (jq_valid),
        .job_found   (jq_found),
        .job_slot    (jq_slot),
        .job_take    (jq_take),
        .meta_re     (meta_re),
        .meta_rslot  (meta_rslot),
        .len_rdata   (len_rdata),
        .src_rdata   (src_rdata),
        .byte_re     (byte_re),
        .byte_raddr  (byte_raddr),
        .byte_rdata  (byte_rdata),
        .active      (back_active),
        .active_slot (back_slot),
        .empty       (empty),
        .pop         (pop),
        .result      (result)
    );

    // no stall when nothing is waiting or being read
    a_idle_not_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!jq_valid && !back_active) |-> !full
    ) else $error("full raised with no pending read");

    // a not-found result ends its run
    a_none_is_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && !result.found) |-> (result.last_of_run && result.msg_length == '0)
    ) else $error("not-found result is not a single last transfer");

    // an empty message carries a zero byte
    a_empty_msg_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && result.msg_length == '0) |-> (result.msg_byte == '0 && result.last_of_run)
    ) else $error("zero-length result carries data");

    // the slot being filled is never overwritten while it is read out
    a_no_write_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        (byte_we && back_active) |-> (back_slot != head_slot)
    ) else $error("write into slot under readout");

endmodule
`default_nettype wire

// ----- verif/omrq_ring_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// omrq_ring_checker
// Watches the item and result channels of the message ring queue. Every
// accepted item is applied to a predictor that keeps its own message slots,
// head and tail, and the results it implies are queued. Each accepted result
// is compared field by field with the oldest queued one. The failure count
// and the number of results still due are handed to the testbench top.
// ----------------------------------------------------------------------------
module omrq_ring_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic              full,
    input  wire omrq_pkg::item_t   item,
    input  wire logic              empty,
    input  wire logic              pop,
    input  wire omrq_pkg::result_t result,
    output int                     fail_count,
    output int                     pending
);

    import omrq_pkg::*;

    localparam int DEPTH      = DEF_QUEUE_DEPTH;
    localparam int SLOT_BYTES = DEF_MAX_BYTES;

    logic [BYTE_W-1:0] ring_bytes [DEPTH][SLOT_BYTES];
    logic [LEN_W-1:0]  ring_len   [DEPTH];
    logic [SRC_W-1:0]  ring_src   [DEPTH];
    int                head_slot;
    int                tail_slot;
    int                fill_bytes;
    result_t           results_due [$];

    function automatic int next_slot(int s);
        return (s == DEPTH - 1) ? 0 : s + 1;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(string name, logic [BYTE_W-1:0] got, logic [BYTE_W-1:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
        end
    endtask

    task automatic emit_not_found();
        result_t r;
        r = '0;
        r.last_of_run = 1'b1;
        results_due.push_back(r);
    endtask

    task automatic emit_message(int s);
        int      count;
        result_t r;
        count = (ring_len[s] == 0) ? 1 : int'(ring_len[s]);
        for (int k = 0; k < count; k++)
        begin
            r.found       = 1'b1;
            r.msg_source  = ring_src[s];
            r.msg_byte    = (ring_len[s] == 0) ? '0 : ring_bytes[s][k];
            r.msg_length  = ring_len[s];
            r.last_of_run = (k == count - 1);
            results_due.push_back(r);
        end
    endtask

    task automatic apply_transfer(item_t it);
        case (it.op)
            OP_PUSH:
            begin
                if (it.byte_valid && fill_bytes < SLOT_BYTES)
                begin
                    ring_bytes[head_slot][fill_bytes] = it.data_byte;
                    fill_bytes++;
                end
                if (it.end_of_message)
                begin
                    ring_len[head_slot] = LEN_W'(fill_bytes);
                    ring_src[head_slot] = it.source;
                    head_slot = next_slot(head_slot);
                    // full ring drops its oldest message
                    if (head_slot == tail_slot)
                    begin
                        tail_slot = next_slot(tail_slot);
                    end
                    fill_bytes = 0;
                end
            end
            OP_POP:
            begin
                if (tail_slot == head_slot)
                begin
                    emit_not_found();
                end
                else
                begin
                    emit_message(tail_slot);
                    tail_slot = next_slot(tail_slot);
                end
            end
            OP_PEEK:
            begin
                if (tail_slot == head_slot)
                begin
                    emit_not_found();
                end
                else
                begin
                    emit_message((head_slot == 0) ? DEPTH - 1 : head_slot - 1);
                end
            end
            OP_CLEAR:
            begin
                tail_slot = head_slot;
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_slot  = 0;
            tail_slot  = 0;
            fill_bytes = 0;
            fail_count = 0;
            results_due.delete();
        end
        else
        begin
            if (pop === 1'b1 && empty === 1'b0)
            begin
                if (results_due.size() == 0)
                begin
                    report_mismatch($sformatf("result transfer with nothing due: %h", result));
                end
                else
                begin
                    check_field("found", BYTE_W'(result.found),
                                BYTE_W'(results_due[0].found));
                    check_field("msg_source", BYTE_W'(result.msg_source),
                                BYTE_W'(results_due[0].msg_source));
                    check_field("msg_byte", result.msg_byte, results_due[0].msg_byte);
                    check_field("msg_length", BYTE_W'(result.msg_length),
                                BYTE_W'(results_due[0].msg_length));
                    check_field("last_of_run", BYTE_W'(result.last_of_run),
                                BYTE_W'(results_due[0].last_of_run));
                    void'(results_due.pop_front());
                end
            end
            if (push === 1'b1 && full === 1'b0)
            begin
                apply_transfer(item);
            end
        end
        pending = results_due.size();
    end

endmodule
`default_nettype wire

// ----- verif/tb_overwriting_message_ring_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_overwriting_message_ring_queue
// Drives the message ring queue with a directed opening (empty queue, empty
// and one-byte messages, clear and pop in the middle of a push), an overlong
// message cut to full length, ring overwrite, a long receiver hold-off, then
// random message sequences mixed with control ops and noise. Both sides idle
// in random bursts. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_overwriting_message_ring_queue;

    import omrq_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS   = 20;
    localparam int QUIET_ITEMS    = 6;
    localparam int SETTLE_CYCLES  = 20;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    push;
    logic    full;
    item_t   item;
    logic    empty;
    logic    pop;
    result_t result;

    int fail_count;
    int pending;
    bit quiet_tail   = 1'b0;
    bit rx_hold      = 1'b0;
    int items_sent   = 0;
    int stall_cycles = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    overwriting_message_ring_queue u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    omrq_ring_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item       (item),
        .empty      (empty),
        .pop        (pop),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push === 1'b1 && full === 1'b0) || (pop === 1'b1 && empty === 1'b0))
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
            end
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("overwriting_message_ring_queue regression: fail");
                $finish;
            end
        end
    end

    // result side
    initial
    begin
        pop <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (rx_hold)
            begin
                pop <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                rx_hold = 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else
            begin
                pop <= 1'b1;
                @(posedge clk);
            end
        end
    end

    function automatic item_t control_item(op_t op);
        item_t it;
        it.op             = op;
        it.source         = SRC_W'($urandom_range(0, 15));
        it.data_byte      = BYTE_W'($urandom_range(0, 255));
        it.byte_valid     = 1'($urandom_range(0, 1));
        it.end_of_message = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic item_t push_item(logic [SRC_W-1:0] src, logic [BYTE_W-1:0] data,
                                        logic bv, logic eom);
        item_t it;
        it.op             = OP_PUSH;
        it.source         = src;
        it.data_byte      = data;
        it.byte_valid     = bv;
        it.end_of_message = eom;
        return it;
    endfunction

    task automatic offer_item(item_t it);
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        item <= it;
        push <= 1'b1;
        do
            @(posedge clk);
        while (full !== 1'b0);
        if (!(it.op == OP_PUSH && !it.byte_valid && !it.end_of_message))
        begin
            items_sent++;
        end
    endtask

    // bytes of one message, optionally with control ops mixed in mid-push
    task automatic send_message(logic [SRC_W-1:0] src, int len, bit mixed);
        bit last_carries_end;
        bit at_end;
        last_carries_end = 1'($urandom_range(0, 1));
        for (int k = 0; k < len; k++)
        begin
            if (mixed && $urandom_range(0, 7) == 0)
            begin
                offer_item(control_item(op_t'(2'($urandom_range(1, 3)))));
            end
            at_end = (k == len - 1) && last_carries_end;
            offer_item(push_item(at_end ? src : SRC_W'($urandom_range(0, 15)),
                                 BYTE_W'($urandom_range(0, 255)), 1'b1, at_end));
        end
        if (len == 0 || !last_carries_end)
        begin
            offer_item(push_item(src, BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1));
        end
    endtask

    task automatic drain_results();
        push <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    initial
    begin
        int base;
        int pick;
        push <= 1'b0;
        item <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // empty queue, ignored item, empty message
        offer_item(control_item(OP_POP));
        offer_item(control_item(OP_PEEK));
        offer_item(push_item(4'hF, 8'hFF, 1'b0, 1'b0));
        offer_item(push_item(4'hF, 8'hFF, 1'b0, 1'b1));
        offer_item(control_item(OP_PEEK));
        offer_item(control_item(OP_POP));
        // byte extremes, last byte carrying the end mark
        offer_item(push_item(4'h7, 8'h00, 1'b1, 1'b0));
        offer_item(push_item(4'h8, 8'hFF, 1'b1, 1'b0));
        offer_item(push_item(4'h0, 8'hA5, 1'b1, 1'b1));
        offer_item(control_item(OP_PEEK));
        offer_item(control_item(OP_POP));
        offer_item(control_item(OP_POP));
        // clear while a message is half pushed
        offer_item(push_item(4'h9, 8'h5A, 1'b0, 1'b1));
        offer_item(push_item(4'h3, 8'h3C, 1'b1, 1'b0));
        offer_item(control_item(OP_CLEAR));
        offer_item(control_item(OP_PEEK));
        offer_item(control_item(OP_POP));
        offer_item(push_item(4'h6, 8'hC3, 1'b1, 1'b1));
        offer_item(control_item(OP_PEEK));
        offer_item(control_item(OP_POP));
        offer_item(control_item(OP_POP));
        // pop while the next message is being pushed
        offer_item(push_item(4'h1, 8'h11, 1'b1, 1'b1));
        offer_item(push_item(4'hE, 8'h22, 1'b1, 1'b0));
        offer_item(control_item(OP_POP));
        offer_item(push_item(4'h2, 8'h00, 1'b0, 1'b1));
        offer_item(control_item(OP_POP));

        // overlong message, stored at full length
        send_message(4'hA, DEF_MAX_BYTES + 1, 1'b0);
        offer_item(control_item(OP_PEEK));
        offer_item(control_item(OP_POP));

        // ring overwrite
        for (int k = 0; k < DEF_QUEUE_DEPTH + 1; k++)
        begin
            offer_item(push_item(SRC_W'(k), BYTE_W'(k * 13), 1'b1, 1'b1));
        end
        offer_item(control_item(OP_PEEK));
        for (int k = 0; k < 2; k++)
        begin
            offer_item(control_item(OP_POP));
        end
        drain_results();

        // receiver holds off while reads keep coming
        rx_hold = 1'b1;
        for (int k = 0; k < 8; k++)
        begin
            offer_item(control_item((k % 4 == 3) ? OP_POP : OP_PEEK));
        end
        drain_results();

        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS)
        begin
            quiet_tail = (items_sent - base >= RANDOM_ITEMS - QUIET_ITEMS);
            pick = int'($urandom_range(0, 19));
            if (pick < 11)
            begin
                send_message(SRC_W'($urandom_range(0, 15)),
                             ($urandom_range(0, 11) == 0) ? int'($urandom_range(7, 12))
                                                          : int'($urandom_range(0, 5)),
                             1'b1);
            end
            else if (pick < 15)
            begin
                offer_item(control_item(OP_POP));
            end
            else if (pick < 17)
            begin
                offer_item(control_item(OP_PEEK));
            end
            else if (pick == 17)
            begin
                offer_item(control_item(OP_CLEAR));
            end
            else
            begin
                offer_item(item_t'(16'($urandom)));
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("overwriting_message_ring_queue regression: pass");
        end
        else
        begin
            $display("overwriting_message_ring_queue regression: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire
